// File: sv/trilinear_vector_field_sampler_assert.svh
// Assertion macros for the trilinear vector field sampler.
`ifndef TRILINEAR_VECTOR_FIELD_SAMPLER_ASSERT_SVH
`define TRILINEAR_VECTOR_FIELD_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVFS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TVFS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tvfs_pkg.sv
// Shared types, codes and constants of the trilinear vector field sampler.
package tvfs_pkg;

  localparam int GRID_MAX_DEF  = 32;
  localparam int COMP_BITS_DEF = 16;

  // Fixed field widths of the item payloads.
  localparam int VOX_W    = 5;
  localparam int COMP_W   = 16;
  localparam int COORD_W  = 18;
  localparam int SIZE_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = FRAC_W + 1;

  typedef logic        [VOX_W-1:0]     vox_t;
  typedef logic signed [COMP_W-1:0]    comp_t;
  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic        [SIZE_W-1:0]    size_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic        [WEIGHT_W-1:0]  weight_t;

  // Action codes of an input item.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Kind codes of a result item.
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SIZE_X = 2'd0;
  localparam cfg_idx_t CFG_SIZE_Y = 2'd1;
  localparam cfg_idx_t CFG_SIZE_Z = 2'd2;

  localparam size_t SIZE_RESET = 6'd32;

  // 1.0 in the Q.16 weight format.
  localparam weight_t ONE_Q16 = 17'h10000;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

endpackage

// File: sv/tvfs_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
interface tvfs_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  tvfs_pkg::vox_t   voxel_x;
  tvfs_pkg::vox_t   voxel_y;
  tvfs_pkg::vox_t   voxel_z;
  tvfs_pkg::comp_t  comp_x;
  tvfs_pkg::comp_t  comp_y;
  tvfs_pkg::comp_t  comp_z;
  tvfs_pkg::coord_t coord_x;
  tvfs_pkg::coord_t coord_y;
  tvfs_pkg::coord_t coord_z;

  modport source (output valid, action, voxel_x, voxel_y, voxel_z, comp_x, comp_y, comp_z,
                  coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, action, voxel_x, voxel_y, voxel_z, comp_x, comp_y, comp_z,
                coord_x, coord_y, coord_z, output ready);
endinterface

interface tvfs_out_if;
  logic            valid;
  logic            ready;
  logic            result_kind;
  tvfs_pkg::comp_t sample_x;
  tvfs_pkg::comp_t sample_y;
  tvfs_pkg::comp_t sample_z;

  modport source (output valid, result_kind, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, result_kind, sample_x, sample_y, sample_z, output ready);
endinterface

interface tvfs_cfg_if;
  logic               valid;
  logic               ready;
  tvfs_pkg::cfg_idx_t index;
  tvfs_pkg::size_t    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/trilinear_vector_field_sampler.sv
// Trilinear vector field sampler: voxel grid store and eight-corner blend.
//
//   channel  dir  carries
//   req      in   action, voxel index, vector to store, query position
//   rsp      out  result kind and interpolated vector
//   cfg      in   grid size per axis (index 0..2)
//
// A write goes from acceptance straight to the finish state; a query first passes
// through the scale, split and corner-run states. The query time is set by the eight corner
// reads through the single grid memory port plus the weight and product stages.
// Reset is synchronous; it sets all sizes to 32 and leaves the grid memory as is.
// A result waits in the output register while the next item is accepted and
// worked on; a finished item holds in its last state until that register frees.
`include "trilinear_vector_field_sampler_assert.svh"

module trilinear_vector_field_sampler #(
  parameter int GRID_MAX  = tvfs_pkg::GRID_MAX_DEF,
  parameter int COMP_BITS = tvfs_pkg::COMP_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  tvfs_in_if.sink      req,
  tvfs_out_if.source   rsp,
  tvfs_cfg_if.sink     cfg
);

  localparam int SB     = (COMP_BITS < tvfs_pkg::COMP_W) ? COMP_BITS : tvfs_pkg::COMP_W;
  localparam int AXB    = $clog2(GRID_MAX);
  localparam int DEPTH  = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int AW     = $clog2(DEPTH);
  localparam int MW     = 3 * SB;
  localparam int WW     = tvfs_pkg::WEIGHT_W;
  localparam int WXY_W  = 2 * tvfs_pkg::FRAC_W + 1;
  localparam int W3_W   = 3 * tvfs_pkg::FRAC_W + 1;
  localparam int PW     = W3_W + 1 + SB;
  localparam int RND_SH = 3 * tvfs_pkg::FRAC_W;
  localparam int OW     = tvfs_pkg::COMP_W;

  localparam logic [AW-1:0] GM = AW'(GRID_MAX);
  localparam logic signed [PW-1:0] HALF = {{(PW-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};
  localparam logic signed [PW-1:0] SMAX = PW'(tvfs_pkg::SAMPLE_MAX);
  localparam logic signed [PW-1:0] SMIN = PW'(tvfs_pkg::SAMPLE_MIN);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [3:0] step;
  logic       v1, v2, v3;
  logic       kz1;

  tvfs_pkg::size_t size_x, size_y, size_z;
  tvfs_pkg::coord_t coord_x_r, coord_y_r, coord_z_r;
  logic kind_r;

  logic [AXB-1:0]    x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  tvfs_pkg::weight_t wx_lo, wx_hi, wy_lo, wy_hi, wz_lo, wz_hi;

  logic              acc_in;
  logic              issue;
  logic              out_load;
  logic              wr_ok;
  logic [2:0]        corner;
  logic [AXB-1:0]    xi, yi, zi;
  tvfs_pkg::weight_t wx_sel, wy_sel, wz_sel;
  logic [2*WW-1:0]   wxy_full;
  logic [WXY_W-1:0]  wxy_r;
  logic [WXY_W+WW-1:0] w3_full;
  logic [W3_W-1:0]   w3_r;
  logic [MW-1:0]     d_r;

  logic              ram_we;
  logic [AW-1:0]     ram_addr, waddr, raddr;
  logic [MW-1:0]     ram_wdata, ram_rdata;

  logic signed [PW-1:0] prod_r [3];
  logic signed [PW-1:0] acc [3];

  logic out_valid;
  logic out_kind;
  tvfs_pkg::comp_t out_x, out_y, out_z;

  // Round half up at the Q.48 point, then saturate to the sample range.
  function automatic logic signed [OW-1:0] round_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + HALF) >>> RND_SH;
    if (t > SMAX) begin
      t = SMAX;
    end else if (t < SMIN) begin
      t = SMIN;
    end
    return t[OW-1:0];
  endfunction

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign acc_in    = req.valid && req.ready;
  assign out_load  = (state == S_FIN) && (!out_valid || rsp.ready);
  assign issue     = (state == S_RUN) && !step[3];

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.sample_x    = out_x;
  assign rsp.sample_y    = out_y;
  assign rsp.sample_z    = out_z;

  tvfs_axis #(.GRID_MAX(GRID_MAX)) u_axis_x (
    .clk(clk), .coord(coord_x_r), .size_reg(size_x),
    .lo(x_lo), .hi(x_hi), .w_lo(wx_lo), .w_hi(wx_hi)
  );
  tvfs_axis #(.GRID_MAX(GRID_MAX)) u_axis_y (
    .clk(clk), .coord(coord_y_r), .size_reg(size_y),
    .lo(y_lo), .hi(y_hi), .w_lo(wy_lo), .w_hi(wy_hi)
  );
  tvfs_axis #(.GRID_MAX(GRID_MAX)) u_axis_z (
    .clk(clk), .coord(coord_z_r), .size_reg(size_z),
    .lo(z_lo), .hi(z_hi), .w_lo(wz_lo), .w_hi(wz_hi)
  );

  // Writes outside the store are dropped but still acknowledged.
  assign wr_ok = (32'(req.voxel_x) < GRID_MAX) && (32'(req.voxel_y) < GRID_MAX) &&
                 (32'(req.voxel_z) < GRID_MAX);
  assign waddr = (AW'(AXB'(req.voxel_z)) * GM + AW'(AXB'(req.voxel_y))) * GM +
                 AW'(AXB'(req.voxel_x));
  assign ram_wdata = {req.comp_z[SB-1:0], req.comp_y[SB-1:0], req.comp_x[SB-1:0]};

  // Corner k picks high x, y, z by its bits 0, 1, 2.
  assign corner = step[2:0];
  assign xi     = corner[0] ? x_hi : x_lo;
  assign yi     = corner[1] ? y_hi : y_lo;
  assign zi     = corner[2] ? z_hi : z_lo;
  assign wx_sel = corner[0] ? wx_hi : wx_lo;
  assign wy_sel = corner[1] ? wy_hi : wy_lo;
  assign wz_sel = kz1 ? wz_hi : wz_lo;
  assign raddr  = (AW'(zi) * GM + AW'(yi)) * GM + AW'(xi);

  assign wxy_full = wx_sel * wy_sel;
  assign w3_full  = wxy_r * wz_sel;

  assign ram_we   = acc_in && (req.action == tvfs_pkg::ACT_WRITE) && wr_ok;
  assign ram_addr = ram_we ? waddr : raddr;

  tvfs_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      size_x    <= tvfs_pkg::SIZE_RESET;
      size_y    <= tvfs_pkg::SIZE_RESET;
      size_z    <= tvfs_pkg::SIZE_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          tvfs_pkg::CFG_SIZE_X: size_x <= cfg.data;
          tvfs_pkg::CFG_SIZE_Y: size_y <= cfg.data;
          tvfs_pkg::CFG_SIZE_Z: size_z <= cfg.data;
          default: ;
        endcase
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc_in) begin
            state <= (req.action == tvfs_pkg::ACT_WRITE) ? S_FIN : S_SCALE;
          end
        end
        S_SCALE: state <= S_SPLIT;
        S_SPLIT: begin
          state <= S_RUN;
          step  <= '0;
        end
        S_RUN: begin
          if (!step[3]) begin
            step <= step + 4'd1;
          end else if (!v1 && !v2) begin
            // The last product lands in the accumulators at this edge.
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      kind_r    <= (req.action == tvfs_pkg::ACT_WRITE) ? tvfs_pkg::KIND_ACK
                                                       : tvfs_pkg::KIND_SAMPLE;
      coord_x_r <= req.coord_x;
      coord_y_r <= req.coord_y;
      coord_z_r <= req.coord_z;
    end
    wxy_r <= wxy_full[WXY_W-1:0];
    kz1   <= corner[2];
    w3_r  <= w3_full[W3_W-1:0];
    d_r   <= ram_rdata;
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= $signed({1'b0, w3_r}) * $signed(d_r[c*SB +: SB]);
      if (acc_in) begin
        acc[c] <= '0;
      end else if (v3) begin
        acc[c] <= acc[c] + prod_r[c];
      end
    end
    if (out_load) begin
      out_kind <= kind_r;
      out_x    <= round_sat(acc[0]);
      out_y    <= round_sat(acc[1]);
      out_z    <= round_sat(acc[2]);
    end
  end

  `TVFS_ASSERT_IMP(a_fin_drained, clk, rst, state == S_FIN, !v1 && !v2 && !v3, "product pipe busy at finish")
  `TVFS_ASSERT_NXT(a_fin_loads, clk, rst, state == S_FIN && out_load, rsp.valid, "finished item not presented")
  `TVFS_ASSERT_IMP(a_pipe_order, clk, rst, v3, $past(v2), "product stage without a data stage")
  `TVFS_ASSERT_IMP(a_no_rw_clash, clk, rst, ram_we, !issue && !v1, "grid write during corner reads")

endmodule

// File: sv/tvfs_ram.sv
// Generic single-port synchronous RAM with registered read data.
module tvfs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/tvfs_axis.sv
// One axis of a query: scale by the grid size, clamp, split into corners and weights.
module tvfs_axis #(
  parameter int GRID_MAX = tvfs_pkg::GRID_MAX_DEF
) (
  input  logic                          clk,
  input  tvfs_pkg::coord_t              coord,
  input  tvfs_pkg::size_t               size_reg,
  output logic [$clog2(GRID_MAX)-1:0]   lo,
  output logic [$clog2(GRID_MAX)-1:0]   hi,
  output tvfs_pkg::weight_t             w_lo,
  output tvfs_pkg::weight_t             w_hi
);

  localparam int AXB  = $clog2(GRID_MAX);
  localparam int SW   = $clog2(GRID_MAX + 1);
  localparam int PW_A = tvfs_pkg::COORD_W + SW + 1;
  localparam int FW   = tvfs_pkg::FRAC_W;

  logic [SW-1:0]          s;
  logic [SW-1:0]          s_m1;
  logic signed [PW_A-1:0] p_r;
  logic signed [PW_A-1:0] top;
  logic signed [PW_A-1:0] pc;
  logic [FW-1:0]          frac;
  logic [AXB-1:0]         lo_c;

  // A zero size counts as one; a size beyond the store saturates.
  always_comb begin
    if (size_reg == '0) begin
      s = SW'(1);
    end else if (32'(size_reg) > GRID_MAX) begin
      s = SW'(GRID_MAX);
    end else begin
      s = SW'(size_reg);
    end
  end

  assign s_m1 = s - SW'(1);
  assign top  = PW_A'({s_m1, {FW{1'b0}}});

  always_comb begin
    if (p_r < 0) begin
      pc = '0;
    end else if (p_r > top) begin
      pc = top;
    end else begin
      pc = p_r;
    end
  end

  assign frac = pc[FW-1:0];
  assign lo_c = pc[FW +: AXB];

  always_ff @(posedge clk) begin
    p_r  <= coord * $signed({1'b0, s});
    lo   <= lo_c;
    hi   <= (frac != '0) ? AXB'(lo_c + AXB'(1)) : lo_c;
    w_hi <= {1'b0, frac};
    w_lo <= tvfs_pkg::ONE_Q16 - {1'b0, frac};
  end

endmodule

// File: tb/tvfs_result_checker.sv
// Checker for the trilinear vector field sampler: predicts every result item and compares it.
`timescale 1ns / 100ps

module tvfs_result_checker (
  input  logic clk,
  input  logic rst,
  tvfs_in_if   req,
  tvfs_out_if  rsp,
  tvfs_cfg_if  cfg,
  output int   errors,
  output int   pending,
  output int   n_samples,
  output int   n_acks
);
  import tvfs_pkg::*;

  localparam int GRID = GRID_MAX_DEF;
  localparam int CELLS = GRID * GRID * GRID;

  typedef struct packed {
    logic  kind;
    comp_t vx;
    comp_t vy;
    comp_t vz;
  } result_t;

  comp_t   grid_mem [0:CELLS-1][0:2];
  size_t   size_reg [0:2];
  result_t due_results [$];

  initial begin
    errors = 0;
    pending = 0;
    n_samples = 0;
    n_acks = 0;
    foreach (grid_mem[i, c]) grid_mem[i][c] = '0;
    foreach (size_reg[a]) size_reg[a] = SIZE_RESET;
  end

  // Scale by the size in use, clamp to the last voxel and split into corners and fraction.
  function automatic void split_axis(input coord_t raw, input size_t cfg_val,
                                     output int unsigned lo, output int unsigned hi,
                                     output logic [63:0] frac);
    longint s, p, lim;
    if (cfg_val == 0) s = 1;
    else if (cfg_val > GRID) s = GRID;
    else s = cfg_val;
    p = longint'(raw) * s;
    lim = (s - 1) * longint'(ONE_Q16);
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    lo = int'(p / longint'(ONE_Q16));
    frac = 64'(p % longint'(ONE_Q16));
    hi = (frac != 0) ? lo + 1 : lo;
  endfunction

  function automatic logic [63:0] corner(input int unsigned x, input int unsigned y,
                                         input int unsigned z, input int c);
    comp_t v;
    v = grid_mem[(z * GRID + y) * GRID + x][c];
    return {{48{v[15]}}, v};
  endfunction

  // Exact blend modulo 2^64; the weights of all eight corners sum to 2^48.
  function automatic logic [63:0] lerp_q16(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] f);
    return a * (64'(ONE_Q16) - f) + b * f;
  endfunction

  // Works out the result of the item on the input channel and applies a write to the grid.
  function automatic result_t apply_item();
    result_t r;
    int unsigned x0, x1, y0, y1, z0, z1;
    logic [63:0] fx, fy, fz, a00, a10, a01, a11, b0, b1, v, u;
    longint q;
    comp_t vec [0:2];
    r = '0;
    if (req.action == ACT_WRITE) begin
      grid_mem[(req.voxel_z * GRID + req.voxel_y) * GRID + req.voxel_x][0] = req.comp_x;
      grid_mem[(req.voxel_z * GRID + req.voxel_y) * GRID + req.voxel_x][1] = req.comp_y;
      grid_mem[(req.voxel_z * GRID + req.voxel_y) * GRID + req.voxel_x][2] = req.comp_z;
      r.kind = KIND_ACK;
      return r;
    end
    split_axis(req.coord_x, size_reg[0], x0, x1, fx);
    split_axis(req.coord_y, size_reg[1], y0, y1, fy);
    split_axis(req.coord_z, size_reg[2], z0, z1, fz);
    for (int c = 0; c < 3; c++) begin
      a00 = lerp_q16(corner(x0, y0, z0, c), corner(x1, y0, z0, c), fx);
      a10 = lerp_q16(corner(x0, y1, z0, c), corner(x1, y1, z0, c), fx);
      a01 = lerp_q16(corner(x0, y0, z1, c), corner(x1, y0, z1, c), fx);
      a11 = lerp_q16(corner(x0, y1, z1, c), corner(x1, y1, z1, c), fx);
      b0 = lerp_q16(a00, a10, fy);
      b1 = lerp_q16(a01, a11, fy);
      v = lerp_q16(b0, b1, fz);
      // Offsetting by 2^63 keeps the sum non-negative, so the shift rounds half up.
      u = v + (64'd1 << 47) + (64'd1 << 63);
      q = longint'(u >> 48) - 32768;
      if (q > SAMPLE_MAX) q = SAMPLE_MAX;
      if (q < SAMPLE_MIN) q = SAMPLE_MIN;
      vec[c] = comp_t'(q);
    end
    r.kind = KIND_SAMPLE;
    r.vx = vec[0];
    r.vy = vec[1];
    r.vz = vec[2];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got, want;
    if (rst) begin
      foreach (size_reg[a]) size_reg[a] = SIZE_RESET;
    end else begin
      // Results are taken before new items, so a result can never match its own item.
      if (rsp.valid && rsp.ready) begin
        got = {rsp.result_kind, rsp.sample_x, rsp.sample_y, rsp.sample_z};
        if (got.kind == KIND_SAMPLE) n_samples++;
        else n_acks++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result item kind %0d vector %0d %0d %0d",
                     $realtime, got.kind, got.vx, got.vy, got.vz);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.vx !== want.vx || got.vy !== want.vy ||
              got.vz !== want.vz) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch, expected kind %0d vector %0d %0d %0d, got kind %0d %s",
                       $realtime, want.kind, want.vx, want.vy, want.vz, got.kind,
                       $sformatf("vector %0d %0d %0d", got.vx, got.vy, got.vz));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SIZE_X: size_reg[0] = cfg.data;
          CFG_SIZE_Y: size_reg[1] = cfg.data;
          CFG_SIZE_Z: size_reg[2] = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) due_results = {due_results, apply_item()};
    end
    pending = due_results.size();
  end

endmodule

// File: tb/trilinear_vector_field_sampler_tb.sv
// Testbench top for the trilinear vector field sampler: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module trilinear_vector_field_sampler_tb;
  import tvfs_pkg::*;

  localparam int GRID = GRID_MAX_DEF;
  localparam int PHASES = 9;
  localparam int DIRECTED_ITEMS = 25;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT_ITEM = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  typedef struct {
    logic   action;
    vox_t   vx, vy, vz;
    comp_t  cx, cy, cz;
    coord_t qx, qy, qz;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   n_sent = 0;
  int   idle_pct = 0;
  int   eff_sz [0:2] = '{32, 32, 32};
  bit   written [0:GRID*GRID*GRID-1];

  // Register values per phase; a negative entry means a random value.
  int plan_x [0:PHASES-1] = '{1, 0, 63, 2, 5, 32, -1, 3, 32};
  int plan_y [0:PHASES-1] = '{1, 40, 2, 0, 3, 32, -1, 4, 32};
  int plan_z [0:PHASES-1] = '{1, 2, 32, 63, 7, 32, -1, 2, 32};
  int plan_idle [0:PHASES-1] = '{20, 0, 50, 10, 35, 0, 60, 25, 0};

  int chk_errors, chk_pending, chk_samples, chk_acks;

  tvfs_in_if  req_ch ();
  tvfs_out_if rsp_ch ();
  tvfs_cfg_if cfg_ch ();

  trilinear_vector_field_sampler dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  tvfs_result_checker result_chk (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
    .errors(chk_errors), .pending(chk_pending), .n_samples(chk_samples), .n_acks(chk_acks)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycles, chk_pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic comp_t rand_comp();
    if ($urandom_range(0, 7) != 0) return comp_t'($urandom);
    case ($urandom_range(0, 3))
      0: return comp_t'(32767);
      1: return comp_t'(-32768);
      2: return comp_t'(0);
      default: return comp_t'(-1);
    endcase
  endfunction

  function automatic coord_t rand_coord(input int sz);
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: return coord_t'((65536 / sz) * $urandom_range(0, sz - 1));
      2: begin
        case ($urandom_range(0, 3))
          0: return coord_t'(-131072);
          1: return coord_t'(131071);
          2: return coord_t'(65536);
          default: return coord_t'(-1);
        endcase
      end
      default: return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Fields that the action does not use still carry random bits.
  function automatic stim_t random_stim();
    stim_t s;
    s.action = $urandom_range(0, 1) ? ACT_QUERY : ACT_WRITE;
    s.vx = vox_t'($urandom);
    s.vy = vox_t'($urandom);
    s.vz = vox_t'($urandom);
    s.cx = comp_t'($urandom);
    s.cy = comp_t'($urandom);
    s.cz = comp_t'($urandom);
    s.qx = coord_t'($urandom);
    s.qy = coord_t'($urandom);
    s.qz = coord_t'($urandom);
    return s;
  endfunction

  // Voxels that a query on this axis will read, under the sizes now in use.
  function automatic void axis_cells(input coord_t c, input int sz, output int lo,
                                     output int hi);
    longint p;
    p = longint'(c) * sz;
    if (p < 0) p = 0;
    if (p > longint'(sz - 1) * 65536) p = longint'(sz - 1) * 65536;
    lo = int'(p / 65536);
    hi = (p % 65536 != 0) ? lo + 1 : lo;
  endfunction

  task automatic send(input stim_t s);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.action <= s.action;
    req_ch.voxel_x <= s.vx;
    req_ch.voxel_y <= s.vy;
    req_ch.voxel_z <= s.vz;
    req_ch.comp_x <= s.cx;
    req_ch.comp_y <= s.cy;
    req_ch.comp_z <= s.cz;
    req_ch.coord_x <= s.qx;
    req_ch.coord_y <= s.qy;
    req_ch.coord_z <= s.qz;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
  endtask

  task automatic store_voxel(input int x, input int y, input int z,
                             input comp_t cx, input comp_t cy, input comp_t cz);
    stim_t s;
    s = random_stim();
    s.action = ACT_WRITE;
    s.vx = vox_t'(x);
    s.vy = vox_t'(y);
    s.vz = vox_t'(z);
    s.cx = cx;
    s.cy = cy;
    s.cz = cz;
    send(s);
    written[(z * GRID + y) * GRID + x] = 1'b1;
  endtask

  // A query is preceded by writes of whichever of its eight corners are still blank.
  task automatic probe(input coord_t qx, input coord_t qy, input coord_t qz);
    int xs [0:1];
    int ys [0:1];
    int zs [0:1];
    stim_t s;
    axis_cells(qx, eff_sz[0], xs[0], xs[1]);
    axis_cells(qy, eff_sz[1], ys[0], ys[1]);
    axis_cells(qz, eff_sz[2], zs[0], zs[1]);
    for (int i = 0; i < 8; i++) begin
      if (!written[(zs[i / 4] * GRID + ys[(i / 2) % 2]) * GRID + xs[i % 2]])
        store_voxel(xs[i % 2], ys[(i / 2) % 2], zs[i / 4], rand_comp(), rand_comp(),
                    rand_comp());
    end
    s = random_stim();
    s.action = ACT_QUERY;
    s.qx = qx;
    s.qy = qy;
    s.qz = qz;
    send(s);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= size_t'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx != CFG_SPARE) eff_sz[idx] = (val == 0) ? 1 : ((val > GRID) ? GRID : val);
  endtask

  // Drains the block: every expected result in, then a pause for the pipeline to empty.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (chk_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: short random stalls, plus one long hold that backs the block up.
  initial begin : result_side
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_sent >= HOLD_AT_ITEM) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if ($urandom_range(0, 99) < idle_pct / 3) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sx, sy, sz;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_WRITE;
    req_ch.voxel_x = '0;
    req_ch.voxel_y = '0;
    req_ch.voxel_z = '0;
    req_ch.comp_x = '0;
    req_ch.comp_y = '0;
    req_ch.comp_z = '0;
    req_ch.coord_x = '0;
    req_ch.coord_y = '0;
    req_ch.coord_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SIZE_X;
    cfg_ch.data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset sizes: extreme vectors, clamped corners, a half-way tie and an integral point.
    store_voxel(0, 0, 0, 32767, -32768, 0);
    store_voxel(1, 0, 0, 1, -1, 32767);
    store_voxel(31, 31, 31, -32768, 32767, -1);
    probe(-131072, -131072, -131072);
    probe(131071, 131071, 131071);
    probe(0, 0, 0);
    probe(1024, 0, 0);
    probe(2048, 0, 0);
    probe(65535, 65536, -1);
    probe(1000, 70000, 33000);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      sx = (plan_x[p] < 0) ? $urandom_range(0, 63) : plan_x[p];
      sy = (plan_y[p] < 0) ? $urandom_range(0, 63) : plan_y[p];
      sz = (plan_z[p] < 0) ? $urandom_range(0, 63) : plan_z[p];
      write_reg(CFG_SIZE_X, sx);
      write_reg(CFG_SIZE_Y, sy);
      write_reg(CFG_SIZE_Z, sz);
      write_reg(CFG_SPARE, $urandom_range(0, 63));
      idle_pct = plan_idle[p];
      while (n_sent < DIRECTED_ITEMS + (p + 1) * ITEMS_PER_PHASE) begin
        // Mostly complete write-then-query sequences; the rest are stray writes anywhere.
        if ($urandom_range(0, 3) == 0)
          store_voxel($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                      $urandom_range(0, GRID - 1), rand_comp(), rand_comp(), rand_comp());
        else
          probe(rand_coord(eff_sz[0]), rand_coord(eff_sz[1]), rand_coord(eff_sz[2]));
      end
    end
    settle();

    $display("Sent %0d items over %0d grid size settings, including zero and oversized sizes.",
             n_sent, PHASES + 1);
    $display("Checked %0d interpolated samples and %0d write acknowledgements.",
             chk_samples, chk_acks);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
